[rtl/matrix3x3_inverse_top_defines.svh]
// Assertion macros for the matrix inverse top level.
// No dependencies; include after the module header.
`ifndef MATRIX3X3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3X3_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define M3I_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define M3I_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/m3i_pkg.sv]
// Package for the 3x3 matrix inverse: payload types, widths, cofactor table.
// No dependencies.
`default_nettype none

package m3i_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LIMIT_W       = 48;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'd281475;

    localparam int COF_W = 2 * DATA_W + 1;   // exact cofactor
    localparam int DET_W = 3 * DATA_W + 3;   // exact determinant
    localparam int COF_LAT = 2;
    localparam int DET_LAT = 4;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;

    typedef struct packed {
        elem_t a_r0c0;
        elem_t a_r0c1;
        elem_t a_r0c2;
        elem_t a_r1c0;
        elem_t a_r1c1;
        elem_t a_r1c2;
        elem_t a_r2c0;
        elem_t a_r2c1;
        elem_t a_r2c2;
    } in_item_t;

    typedef struct packed {
        elem_t inv_r0c0;
        elem_t inv_r0c1;
        elem_t inv_r0c2;
        elem_t inv_r1c0;
        elem_t inv_r1c1;
        elem_t inv_r1c2;
        elem_t inv_r2c0;
        elem_t inv_r2c1;
        elem_t inv_r2c2;
        logic  is_invertible;
    } out_item_t;

    typedef struct packed {
        logic neg;
        logic sing;
    } det_info_t;

    // adjugate entry k = a[p]*a[q] - a[r]*a[s], entries row*3+col
    typedef int unsigned adj_row_t [4];
    localparam adj_row_t ADJ_TBL [9] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

`default_nettype wire

[rtl/m3i_cof_lane.sv]
// One cofactor lane: two registered products and their difference.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cof_lane
    import m3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire elem_t a_p,
    input  wire elem_t a_q,
    input  wire elem_t a_r,
    input  wire elem_t a_s,
    output cof_t       cof
);

    logic signed [2*DATA_W-1:0] p1_reg, p2_reg;
    cof_t cof_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= a_p * a_q;
            p2_reg  <= a_r * a_s;
            cof_reg <= COF_W'(p1_reg) - COF_W'(p2_reg);
        end
    end

    assign cof = cof_reg;

endmodule

`default_nettype wire

[rtl/m3i_det.sv]
// Determinant merge stage: combines row 0 with three cofactor lanes.
// Depends on m3i_pkg; carries all nine cofactors alongside.
`default_nettype none

module m3i_det
    import m3i_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire elem_t              row0 [3],
    input  wire cof_t               cof_in [9],
    input  wire logic [LIMIT_W-1:0] limit,
    output cof_t                    cof_out [9],
    output logic [DET_W-1:0]        dabs,
    output det_info_t               info
);

    logic signed [2*DATA_W:0] pl_reg [3];
    logic signed [2*DATA_W:0] ph_reg [3];
    logic signed [DET_W-1:0]  prod_reg [3];
    logic signed [DET_W-1:0]  det_reg;
    logic [DET_W-1:0]         dabs_reg;
    det_info_t                info_reg;
    cof_t                     cpipe_reg [DET_LAT][9];
    logic [DET_W-1:0]         dabs_next;

    localparam int CIDX [3] = '{0, 3, 6};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // split the cofactor into an unsigned low half and signed high part
                pl_reg[j] <= row0[j] *
                    $signed({1'b0, cof_in[CIDX[j]][DATA_W-1:0]});
                ph_reg[j] <= row0[j] * $signed(cof_in[CIDX[j]][COF_W-1:DATA_W]);
                prod_reg[j] <= (DET_W'(ph_reg[j]) <<< DATA_W) + DET_W'(pl_reg[j]);
            end
            det_reg       <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            dabs_reg      <= dabs_next;
            info_reg.neg  <= det_reg[DET_W-1];
            info_reg.sing <= (dabs_next == '0) || (dabs_next < DET_W'(limit));
            cpipe_reg[0]  <= cof_in;
            for (int s = 1; s < DET_LAT; s++)
            begin
                cpipe_reg[s] <= cpipe_reg[s-1];
            end
        end
    end

    assign dabs_next = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    assign cof_out   = cpipe_reg[DET_LAT-1];
    assign dabs      = dabs_reg;
    assign info      = info_reg;

endmodule

`default_nettype wire

[rtl/m3i_div_lane.sv]
// One divider lane: rounded cofactor/determinant quotient, one bit per stage,
// then saturation, or zero for a singular determinant. Depends on m3i_pkg.
`default_nettype none

module m3i_div_lane
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire cof_t             cof,
    input  wire logic [DET_W-1:0] dabs,
    input  wire det_info_t        info,
    output elem_t                 result
);

    localparam int SH_W  = 2 * DATA_W + 2 * FRAC_BITS + 1;
    localparam int NUM_W = ((SH_W > DET_W - 1) ? SH_W : DET_W - 1) + 1;
    localparam int SW    = (NUM_W > DET_W + DATA_W) ? NUM_W : DET_W + DATA_W;

    logic [SW-1:0]     rem_reg [DATA_W+1];
    logic [SW-1:0]     den_reg [DATA_W+1];
    logic [DATA_W-1:0] q_reg   [DATA_W+1];
    logic              neg_reg [DATA_W+1];
    logic              ovf_reg [DATA_W+1];
    logic              sing_reg [DATA_W+1];
    elem_t             result_reg;

    logic [COF_W-1:0]  mag;
    logic [SW-1:0]     num, den;
    logic [DATA_W-1:0] qmag;
    logic [DATA_W-1:0] sat_mag;

    localparam logic [DATA_W-1:0] BOUND = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] PMAX  = {1'b0, {(DATA_W-1){1'b1}}};

    assign mag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
    assign num = (SW'(mag) << (2 * FRAC_BITS + 1)) + SW'(dabs);
    assign den = SW'(dabs) << 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            neg_reg[0]  <= cof[COF_W-1] ^ info.neg;
            ovf_reg[0]  <= num >= (den << DATA_W);
            sing_reg[0] <= info.sing;
        end
    end

    for (genvar s = 0; s < DATA_W; s++)
    begin : g_step
        localparam int SH = DATA_W - 1 - s;
        logic [SW-1:0] trial;
        assign trial = den_reg[s] << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[s] >= trial)
                begin
                    rem_reg[s+1]   <= rem_reg[s] - trial;
                    q_reg[s+1]     <= q_reg[s] | (DATA_W'(1) << SH);
                end
                else
                begin
                    rem_reg[s+1]   <= rem_reg[s];
                    q_reg[s+1]     <= q_reg[s];
                end
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    always_comb
    begin
        qmag = q_reg[DATA_W];
        if (neg_reg[DATA_W])
        begin
            sat_mag = (ovf_reg[DATA_W] || qmag > BOUND) ? BOUND : qmag;
        end
        else
        begin
            sat_mag = (ovf_reg[DATA_W] || qmag > PMAX) ? PMAX : qmag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sing_reg[DATA_W])
            begin
                result_reg <= '0;
            end
            else
            begin
                result_reg <= neg_reg[DATA_W] ? elem_t'(-sat_mag) : elem_t'(sat_mag);
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/matrix3x3_inverse_top.sv]
// Top level of the 3x3 matrix inverse: cofactor lanes, determinant merge,
// divider lanes and the output skid. Depends on m3i_pkg and all m3i_ modules.
`default_nettype none

// Inverts one 3x3 signed fixed-point matrix per transfer by the adjugate
// method and accepts a new matrix every clock cycle while in_ready is high,
// that is while the skid entry is free. A transfer passes in order through
// the nine cofactor lanes, the determinant merge, the nine divider lanes,
// which resolve one quotient bit per stage, and the output register. A
// result whose determinant magnitude is zero or below singular_limit
// (written via limit_we/limit_wdata, 48-bit, 2^-48 units) comes out with all
// entries zero and is_invertible low; otherwise entries are rounded to
// nearest (ties away from zero) and saturated. An output register plus a
// skid entry let the pipeline keep taking transfers while one result waits
// for out_ready; the whole pipeline holds only when both are full.

module matrix3x3_inverse_top
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               limit_we,
    input  wire logic [LIMIT_W-1:0] limit_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data
);

`include "matrix3x3_inverse_top_defines.svh"

    localparam int DIV_LAT = DATA_W + 2;
    localparam int LAT     = COF_LAT + DET_LAT + DIV_LAT;

    logic [LIMIT_W-1:0] limit_reg;
    logic               vld_reg [LAT];
    logic               inv_dly_reg [DIV_LAT];
    elem_t              row0_reg [COF_LAT][3];
    out_item_t          out_data_reg, skid_data_reg;
    logic               out_vld_reg, skid_vld_reg;

    logic      adv;
    elem_t     a_vec [9];
    cof_t      cof [9];
    cof_t      cof_d [9];
    logic [DET_W-1:0] dabs;
    det_info_t info;
    elem_t     res [9];
    out_item_t end_item;
    logic      take;

    // Advance the whole pipeline whenever the skid entry is free.
    assign adv      = !skid_vld_reg;
    assign in_ready = adv;

    assign a_vec[0] = in_data.a_r0c0;
    assign a_vec[1] = in_data.a_r0c1;
    assign a_vec[2] = in_data.a_r0c2;
    assign a_vec[3] = in_data.a_r1c0;
    assign a_vec[4] = in_data.a_r1c1;
    assign a_vec[5] = in_data.a_r1c2;
    assign a_vec[6] = in_data.a_r2c0;
    assign a_vec[7] = in_data.a_r2c1;
    assign a_vec[8] = in_data.a_r2c2;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (limit_we)
        begin
            limit_reg <= limit_wdata;
        end
    end

    // Valid line tracks each transfer through the fixed-latency datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Nine cofactor lanes.
    for (genvar k = 0; k < 9; k++)
    begin : g_cof
        m3i_cof_lane u_cof (
            .clk (clk),
            .en  (adv),
            .a_p (a_vec[ADJ_TBL[k][0]]),
            .a_q (a_vec[ADJ_TBL[k][1]]),
            .a_r (a_vec[ADJ_TBL[k][2]]),
            .a_s (a_vec[ADJ_TBL[k][3]]),
            .cof (cof[k])
        );
    end

    // Hold row 0 alongside the cofactor lanes for the determinant.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row0_reg[0] <= '{a_vec[0], a_vec[1], a_vec[2]};
            for (int s = 1; s < COF_LAT; s++)
            begin
                row0_reg[s] <= row0_reg[s-1];
            end
        end
    end

    m3i_det u_det (
        .clk     (clk),
        .en      (adv),
        .row0    (row0_reg[COF_LAT-1]),
        .cof_in  (cof),
        .limit   (limit_reg),
        .cof_out (cof_d),
        .dabs    (dabs),
        .info    (info)
    );

    // Nine divider lanes.
    for (genvar k = 0; k < 9; k++)
    begin : g_div
        m3i_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk    (clk),
            .en     (adv),
            .cof    (cof_d[k]),
            .dabs   (dabs),
            .info   (info),
            .result (res[k])
        );
    end

    // Carry the invertible flag past the divider lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_dly_reg[0] <= !info.sing;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                inv_dly_reg[s] <= inv_dly_reg[s-1];
            end
        end
    end

    assign end_item.inv_r0c0      = res[0];
    assign end_item.inv_r0c1      = res[1];
    assign end_item.inv_r0c2      = res[2];
    assign end_item.inv_r1c0      = res[3];
    assign end_item.inv_r1c1      = res[4];
    assign end_item.inv_r1c2      = res[5];
    assign end_item.inv_r2c0      = res[6];
    assign end_item.inv_r2c1      = res[7];
    assign end_item.inv_r2c2      = res[8];
    assign end_item.is_invertible = inv_dly_reg[DIV_LAT-1];

    assign take = vld_reg[LAT-1] && adv;

    // Output register with one skid entry: drain the skid first, else load
    // straight from the pipeline; park in the skid while the output stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= take;
            end
        end
        else if (take)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (take)
            begin
                out_data_reg <= end_item;
            end
        end
        else if (take)
        begin
            skid_data_reg <= end_item;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    `M3I_ASSERT_NOW(a_skid_implies_out, clk, rst_n, skid_vld_reg, out_vld_reg,
        "skid entry holds a result while the output register is empty")
    `M3I_ASSERT_NEXT(a_out_hold, clk, rst_n, out_vld_reg && !out_ready,
        out_vld_reg && $stable(out_data_reg), "stalled result changed")
    `M3I_ASSERT_NOW(a_skid_fill, clk, rst_n, $rose(skid_vld_reg),
        $past(out_vld_reg && !out_ready), "skid filled while output was free")
    `M3I_ASSERT_NOW(a_singular_zero, clk, rst_n,
        out_vld_reg && !out_data_reg.is_invertible,
        out_data_reg.inv_r0c0 == '0 && out_data_reg.inv_r1c1 == '0 &&
        out_data_reg.inv_r2c2 == '0, "singular result carries nonzero entries")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for matrix3x3_inverse_top: adjugate inverse with singular detection.
// Depends on m3i_pkg and the matrix3x3_inverse_top RTL; no other files.
`timescale 1ns / 100ps

module testbench;
    import m3i_pkg::*;

    localparam int TBL [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
    localparam int DRAIN_CYCLES = 3 * DATA_W + 60;

    logic               clk;
    logic               rst_n;
    logic               limit_we;
    logic [LIMIT_W-1:0] limit_wdata;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;

    // testbench copy of the singular limit, updated with each register write
    logic [LIMIT_W-1:0] limit_copy;
    in_item_t           matrix_q[$];
    out_item_t          inverse_q[$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 mismatches;

    matrix3x3_inverse_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Compute the inverse: exact cofactors and determinant at 128 bits, then
    // round-to-nearest division (ties away from zero) and saturation; all zero when singular.
    function automatic out_item_t invert_matrix(in_item_t m, logic [LIMIT_W-1:0] lim);
        logic signed [127:0] a[9];
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic [127:0]        dabs;
        logic [127:0]        cabs;
        logic [127:0]        q;
        logic [DATA_W-1:0]   mag;
        logic                neg;
        logic [9*DATA_W:0]   flat;
        logic [9*DATA_W-1:0] mbits;
        mbits = m;
        flat = '0;
        for (int k = 0; k < 9; k++)
        begin
            a[k] = $signed(mbits[(8-k)*DATA_W +: DATA_W]);
        end
        for (int k = 0; k < 9; k++)
        begin
            adj[k] = a[TBL[k][0]] * a[TBL[k][1]] - a[TBL[k][2]] * a[TBL[k][3]];
        end
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        dabs = det[127] ? -det : det;
        if (det == 0 || dabs < {80'd0, lim})
        begin
            return out_item_t'(flat);
        end
        for (int k = 0; k < 9; k++)
        begin
            neg = adj[k][127] ^ det[127];
            cabs = adj[k][127] ? -adj[k] : adj[k];
            q = ((cabs << (2 * FRAC_BITS_DEF + 1)) + dabs) / (dabs << 1);
            if (neg && q > (128'd1 << (DATA_W - 1)))
                q = 128'd1 << (DATA_W - 1);
            else if (!neg && q > ((128'd1 << (DATA_W - 1)) - 1))
                q = (128'd1 << (DATA_W - 1)) - 1;
            mag = q[DATA_W-1:0];
            flat[(8-k)*DATA_W + 1 +: DATA_W] = neg ? -mag : mag;
        end
        flat[0] = 1'b1;
        return out_item_t'(flat);
    endfunction

    // Driver: hold the payload until the transfer, then advance from the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                inverse_q.push_back(invert_matrix(in_data, limit_copy));
            end
            if (in_valid && !in_ready)
            begin
                // hold
            end
            else if (matrix_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= matrix_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t           want;
        logic [9*DATA_W:0]   wv;
        logic [9*DATA_W:0]   gv;
        logic                bad;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    want = inverse_q.pop_front();
                    wv = want;
                    gv = out_data;
                    bad = 1'b0;
                    for (int k = 0; k < 9; k++)
                    begin
                        if (wv[(8-k)*DATA_W + 1 +: DATA_W] !== gv[(8-k)*DATA_W + 1 +: DATA_W])
                        begin
                            bad = 1'b1;
                            if (mismatches < 10)
                                $display("entry r%0dc%0d: expected %h actual %h", k / 3, k % 3,
                                         wv[(8-k)*DATA_W + 1 +: DATA_W],
                                         gv[(8-k)*DATA_W + 1 +: DATA_W]);
                        end
                    end
                    if (wv[0] !== gv[0])
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("is_invertible: expected %b actual %b", wv[0], gv[0]);
                    end
                    if (bad)
                        mismatches++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Random entry: full range, near one, tiny (drives saturation), or zero.
    function automatic elem_t rand_entry(int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(262144)) - 131072);
            2: return elem_t'($signed($urandom_range(512)) - 256);
            default: return '0;
        endcase
    endfunction

    function automatic in_item_t rand_matrix();
        logic [9*DATA_W-1:0] v;
        int                  kind;
        int                  sel;
        sel = $urandom_range(99);
        kind = (sel < 20) ? 0 : (sel < 75) ? 1 : (sel < 90) ? 2 : 3;
        for (int k = 0; k < 9; k++)
        begin
            v[(8-k)*DATA_W +: DATA_W] = rand_entry(kind == 3 ? 1 : kind);
            if ($urandom_range(19) == 0)
                v[(8-k)*DATA_W +: DATA_W] = '0;
        end
        // near-singular: row 2 is row 0 plus a little noise
        if (kind == 3)
        begin
            for (int c = 0; c < 3; c++)
            begin
                v[(2-c)*DATA_W +: DATA_W] = v[(8-c)*DATA_W +: DATA_W] + rand_entry(2) / 16;
            end
        end
        return in_item_t'(v);
    endfunction

    function automatic in_item_t diag_matrix(elem_t d0, elem_t d1, elem_t d2, elem_t off);
        in_item_t m;
        m = '{off, off, off, off, off, off, off, off, off};
        m.a_r0c0 = d0;
        m.a_r1c1 = d1;
        m.a_r2c2 = d2;
        return m;
    endfunction

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        limit_we    <= 1'b1;
        limit_wdata <= value;
        limit_copy  = value;
        @(posedge clk);
        limit_we    <= 1'b0;
    endtask

    // Wait until every matrix has been sent and every prediction matched.
    task automatic drain();
        while (matrix_q.size() > 0 || in_valid || inverse_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        elem_t one;
        elem_t mx;
        elem_t mn;
        one = 32'sh0001_0000;
        mx  = 32'sh7fff_ffff;
        mn  = 32'sh8000_0000;
        rst_n         = 1'b0;
        limit_we      = 1'b0;
        limit_wdata   = '0;
        limit_copy    = LIMIT_RESET;
        mismatches    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 71;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit, then with limit zero.
        matrix_q.push_back(diag_matrix(one, one, one, '0));            // identity
        matrix_q.push_back(diag_matrix('0, '0, '0, '0));               // zero det
        matrix_q.push_back(diag_matrix(mx, mx, mx, '0));               // largest entries
        matrix_q.push_back(diag_matrix(mn, mn, mn, '0));               // most negative
        matrix_q.push_back(diag_matrix(mn, mx, mn, mx));
        matrix_q.push_back(diag_matrix(mx, mx, mx, mx));               // rank one
        matrix_q.push_back(diag_matrix(32'sd1, 32'sd1, 32'sd1, '0));   // det of one lsb
        matrix_q.push_back(diag_matrix(32'sd64, 32'sd64, 32'sd64, '0)); // below reset limit
        matrix_q.push_back(diag_matrix(32'sd65, 32'sd65, 32'sd65, '0)); // still just below
        matrix_q.push_back(diag_matrix(-32'sd256, 32'sd256, 32'sd256, '0)); // negative diagonal
        matrix_q.push_back(diag_matrix(one * 2, -one, one * 4, 32'sh0000_8000));
        matrix_q.push_back(diag_matrix(one * 3, one * 3, one * 3, '0)); // rounding of 1/3
        drain();
        write_limit('0);
        matrix_q.push_back(diag_matrix(32'sd1, 32'sd1, 32'sd1, '0));
        matrix_q.push_back(diag_matrix('0, '0, '0, '0));
        matrix_q.push_back(diag_matrix(-32'sd1, 32'sd1, 32'sd1, '0));
        matrix_q.push_back(diag_matrix(32'sd64, 32'sd64, 32'sd64, '0));
        for (int i = 0; i < 140; i++)
            matrix_q.push_back(rand_matrix());
        drain();

        // Largest limit, idling swapped.
        write_limit(LIMIT_MAX);
        send_idle_pct = 71;
        recv_idle_pct = 25;
        for (int i = 0; i < 150; i++)
            matrix_q.push_back(rand_matrix());
        drain();

        // Random limit, no idling at all.
        write_limit({$urandom_range(65535), $urandom} & {16'h0000, 32'h00ff_ffff} |
                    LIMIT_W'($urandom_range(1) << 47) >> $urandom_range(47));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 150; i++)
            matrix_q.push_back(rand_matrix());
        drain();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
